### src/bsa_pkg.sv
// Package for the banker's safety allocator.
// Holds command codes for the top level and status codes shared by the top level and the checker.
package bsa_pkg;
   localparam logic [1:0] CMD_LOAD_AVAIL = 2'd0;
   localparam logic [1:0] CMD_LOAD_MAX   = 2'd1;
   localparam logic [1:0] CMD_REQUEST    = 2'd2;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam logic [1:0] ST_LOADED      = 2'd0;
   localparam logic [1:0] ST_GRANTED     = 2'd1;
   localparam logic [1:0] ST_REFUSED     = 2'd2;
   localparam logic [1:0] ST_UNSAFE      = 2'd3;
endpackage

### src/bsa_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module bsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### src/banker_safety_allocator.sv
// Top level of the banker's safety allocator.
// Depends on bsa_pkg and bsa_ram.
//
// One item at a time. start is taken while busy is low; exactly one result
// comes back on rsp_valid for a single cycle and cannot be held off.
// Allocation and need rows (one row per process, all resources side by side)
// live in two single-port RAMs with a registered read. After reset a
// clearing pass zeroes every row of both RAMs with busy high. A load or a
// refused request passes through S_RD, S_EXEC and S_DONE with busy high,
// and its result follows in the next cycle. A checked request goes through
// S_RD and S_EXEC, then the safety scan visits each process row in
// S_SCAN_RD and S_SCAN, since the compare waits for the registered read.
// Each pass starts again at row 0 and stops at the first row that fits,
// so for eight processes the scan visits at most 43 rows (seven passes
// ending at the highest rows and one failed full pass), or 36 rows when
// every process finishes. S_FIN_RD and S_FIN then end the check, S_FIN
// rolling back an unsafe grant, with busy high through S_DONE; the result
// comes next, and the single read port of the row RAMs sets the scan rate.
module banker_safety_allocator #(
   parameter int RESOURCE_TYPES = 3,
   parameter int PROCESS_SLOTS  = 8,
   parameter int UNIT_BITS      = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_process,
   input  logic [1:0]  req_resource,
   input  logic [15:0] req_amount,
   input  logic [15:0] req_req_0,
   input  logic [15:0] req_req_1,
   input  logic [15:0] req_req_2,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_finished_count
);
   localparam int PW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
   localparam int RW = RESOURCE_TYPES * UNIT_BITS;
   localparam int CW = $clog2(PROCESS_SLOTS + 1);
   localparam logic [UNIT_BITS-1:0] UMAX = '1;

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2,
      S_EXEC = 4'd3, S_SCAN_RD = 4'd4, S_SCAN = 4'd5, S_FIN_RD = 4'd6,
      S_FIN = 4'd7, S_DONE = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [2:0] proc_ff, proc_in;
   logic [1:0] res_ff, res_in;
   logic [UNIT_BITS-1:0] amt_ff, amt_in;
   logic [RW-1:0] rq_ff, rq_in;
   logic rq_big_ff, rq_big_in;
   logic [UNIT_BITS-1:0] avail_ff [RESOURCE_TYPES];
   logic [UNIT_BITS-1:0] avail_in [RESOURCE_TYPES];
   logic [UNIT_BITS-1:0] work_ff [RESOURCE_TYPES];
   logic [UNIT_BITS-1:0] work_in [RESOURCE_TYPES];
   logic [PROCESS_SLOTS-1:0] fin_ff, fin_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] pass_ff, pass_in;
   logic [1:0] st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic vld_ff, vld_in;

   logic we;
   logic [PW-1:0] addr;
   logic [RW-1:0] alloc_wd, need_wd, alloc_rd, need_rd;

   bsa_ram #(.WIDTH(RW), .DEPTH(PROCESS_SLOTS)) u_alloc (
      .clock, .we, .addr, .wdata(alloc_wd), .rdata(alloc_rd));
   bsa_ram #(.WIDTH(RW), .DEPTH(PROCESS_SLOTS)) u_need (
      .clock, .we, .addr, .wdata(need_wd), .rdata(need_rd));

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_status = st_ff;
   assign rsp_finished_count = 4'(cnt_ff);

   // The request fits when the process is in range and every amount is
   // within both its need and the available count. An amount wider than a
   // unit count can never fit.
   logic req_ok, fits;
   logic [UNIT_BITS:0] wsum;
   always_comb begin
      req_ok = (32'(proc_ff) < PROCESS_SLOTS) && !rq_big_ff;
      fits = 1'b1;
      for (int r = 0; r < RESOURCE_TYPES; r++) begin
         if (rq_ff[r*UNIT_BITS +: UNIT_BITS] > need_rd[r*UNIT_BITS +: UNIT_BITS] ||
             rq_ff[r*UNIT_BITS +: UNIT_BITS] > avail_ff[r]) begin
            req_ok = 1'b0;
         end
         if (need_rd[r*UNIT_BITS +: UNIT_BITS] > work_ff[r]) begin
            fits = 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; proc_in = proc_ff; res_in = res_ff;
      amt_in = amt_ff; rq_in = rq_ff; rq_big_in = rq_big_ff; fin_in = fin_ff;
      ptr_in = ptr_ff; pass_in = pass_ff; st_in = st_ff; cnt_in = cnt_ff;
      vld_in = 1'b0;
      avail_in = avail_ff; work_in = work_ff;
      we = 1'b0; addr = proc_ff[PW-1:0];
      alloc_wd = alloc_rd; need_wd = need_rd;
      wsum = '0;
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1; addr = ptr_ff; alloc_wd = '0; need_wd = '0;
            ptr_in = ptr_ff + 1'b1;
            if (32'(ptr_ff) == PROCESS_SLOTS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in = req_cmd; proc_in = req_process; res_in = req_resource;
               amt_in = UNIT_BITS'(req_amount > 16'(UMAX) ? 16'(UMAX) : req_amount);
               rq_big_in = (req_req_0 > 16'(UMAX)) ||
                  (RESOURCE_TYPES > 1 && req_req_1 > 16'(UMAX)) ||
                  (RESOURCE_TYPES > 2 && req_req_2 > 16'(UMAX));
               rq_in = '0;
               rq_in[0 +: UNIT_BITS] = UNIT_BITS'(req_req_0);
               if (RESOURCE_TYPES > 1) rq_in[UNIT_BITS*(RESOURCE_TYPES>1) +: UNIT_BITS] =
                  UNIT_BITS'(req_req_1);
               if (RESOURCE_TYPES > 2) rq_in[UNIT_BITS*2*(RESOURCE_TYPES>2) +: UNIT_BITS] =
                  UNIT_BITS'(req_req_2);
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            st_in = bsa_pkg::ST_LOADED; cnt_in = '0;
            state_in = S_DONE;
            if (cmd_ff == bsa_pkg::CMD_LOAD_AVAIL) begin
               for (int r = 0; r < RESOURCE_TYPES; r++)
                  if (32'(res_ff) == r) avail_in[r] = amt_ff;
            end else if (cmd_ff == bsa_pkg::CMD_LOAD_MAX) begin
               if (32'(proc_ff) < PROCESS_SLOTS) begin
                  for (int r = 0; r < RESOURCE_TYPES; r++)
                     if (32'(res_ff) == r) begin
                        we = 1'b1;
                        need_wd[r*UNIT_BITS +: UNIT_BITS] =
                           amt_ff > alloc_rd[r*UNIT_BITS +: UNIT_BITS] ?
                           amt_ff - alloc_rd[r*UNIT_BITS +: UNIT_BITS] : '0;
                     end
               end
            end else if (cmd_ff == bsa_pkg::CMD_REQUEST) begin
               if (!req_ok) begin
                  st_in = bsa_pkg::ST_REFUSED;
               end else begin
                  // Tentative grant; rolled back at the end if unsafe.
                  we = 1'b1;
                  for (int r = 0; r < RESOURCE_TYPES; r++) begin
                     avail_in[r] = avail_ff[r] - rq_ff[r*UNIT_BITS +: UNIT_BITS];
                     work_in[r] = avail_in[r];
                     alloc_wd[r*UNIT_BITS +: UNIT_BITS] = alloc_rd[r*UNIT_BITS +: UNIT_BITS]
                        + rq_ff[r*UNIT_BITS +: UNIT_BITS];
                     need_wd[r*UNIT_BITS +: UNIT_BITS] = need_rd[r*UNIT_BITS +: UNIT_BITS]
                        - rq_ff[r*UNIT_BITS +: UNIT_BITS];
                  end
                  fin_in = '0; ptr_in = '0; pass_in = '0;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            addr = ptr_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // Row ptr_ff is on the read port now.
            addr = ptr_ff;
            if (!fin_ff[ptr_ff] && fits) begin
               fin_in[ptr_ff] = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               for (int r = 0; r < RESOURCE_TYPES; r++) begin
                  wsum = {1'b0, work_ff[r]} + {1'b0, alloc_rd[r*UNIT_BITS +: UNIT_BITS]};
                  work_in[r] = wsum[UNIT_BITS] ? UMAX : wsum[UNIT_BITS-1:0];
               end
               pass_in = pass_ff + 1'b1;
               ptr_in = '0;
               if (32'(pass_ff) == PROCESS_SLOTS - 1) state_in = S_FIN_RD;
               else state_in = S_SCAN_RD;
            end else if (32'(ptr_ff) == PROCESS_SLOTS - 1) begin
               state_in = S_FIN_RD;
            end else begin
               ptr_in = ptr_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_FIN_RD: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = S_DONE;
            if (32'(cnt_ff) == PROCESS_SLOTS) begin
               st_in = bsa_pkg::ST_GRANTED;
            end else begin
               st_in = bsa_pkg::ST_UNSAFE;
               we = 1'b1;
               for (int r = 0; r < RESOURCE_TYPES; r++) begin
                  avail_in[r] = avail_ff[r] + rq_ff[r*UNIT_BITS +: UNIT_BITS];
                  alloc_wd[r*UNIT_BITS +: UNIT_BITS] = alloc_rd[r*UNIT_BITS +: UNIT_BITS]
                     - rq_ff[r*UNIT_BITS +: UNIT_BITS];
                  need_wd[r*UNIT_BITS +: UNIT_BITS] = need_rd[r*UNIT_BITS +: UNIT_BITS]
                     + rq_ff[r*UNIT_BITS +: UNIT_BITS];
               end
            end
         end
         S_DONE: begin
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff <= '0;
         vld_ff <= 1'b0;
         fin_ff <= '0;
         cnt_ff <= '0;
         for (int r = 0; r < RESOURCE_TYPES; r++) begin
            avail_ff[r] <= '0;
            work_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         vld_ff <= vld_in;
         fin_ff <= fin_in;
         cnt_ff <= (state_ff == S_IDLE) ? '0 : cnt_in;
         avail_ff <= avail_in;
         work_ff <= work_in;
      end
      cmd_ff <= cmd_in; proc_ff <= proc_in; res_ff <= res_in; amt_ff <= amt_in;
      rq_ff <= rq_in; rq_big_ff <= rq_big_in; pass_ff <= pass_in; st_ff <= st_in;
   end
endmodule

### src/bsa_checker.sv
// Port-level checker for the banker's safety allocator, bound to the top.
// Depends on bsa_pkg.
module bsa_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_finished_count
);
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than a cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");
   a_grant_all: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bsa_pkg::ST_GRANTED) |-> rsp_finished_count != 4'd0)
      else $error("grant with no finished processes");
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == bsa_pkg::ST_LOADED ||
       rsp_status == bsa_pkg::ST_REFUSED)) |-> rsp_finished_count == 4'd0)
      else $error("count without a safety check");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
endmodule

bind banker_safety_allocator bsa_checker u_bsa_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_status, .rsp_finished_count);
